### design/modbus_rtu_read_master_assert.svh
// ----------------------------------------------------------------------------
// Modbus RTU read master assertion macros
// Shared property forms for the port checker. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_MASTER_ASSERT_SVH
`define MODBUS_RTU_READ_MASTER_ASSERT_SVH

// same-cycle implication
`define MRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modbus read master: same-cycle check failed");

// next-cycle implication
`define MRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modbus read master: next-cycle check failed");

`endif

### design/mrm_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU read master package
// Beat types, sizing constants, state encoding and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int MaxFrame   = 32;
  localparam int MaxRegs    = 16;
  localparam int CountCap   = (MaxRegs > 16) ? 16 : ((MaxRegs < 1) ? 1 : MaxRegs);
  localparam int PosW       = $clog2(MaxFrame + 1);
  localparam int PosExtW    = 7;
  localparam int StoreDepth = 16;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int TxIdxW     = 3;

  localparam logic [15:0]       CrcPoly   = 16'hA001;
  localparam logic [15:0]       CrcInit   = 16'hFFFF;
  localparam logic [TxIdxW-1:0] TxCrcLo   = 3'd6;
  localparam logic [TxIdxW-1:0] TxLastIdx = 3'd7;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_REJECT = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TX,
    ST_RD,
    ST_WORD,
    ST_REJ
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [4:0]  reg_count;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_item_t;

  typedef struct packed {
    out_kind_t   out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [3:0]  reg_index;
    logic        frame_ok;
    logic        last;
  } res_item_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/mrm_ram.sv
// ----------------------------------------------------------------------------
// Modbus RTU read master register store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mrm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/mrm_ctrl.sv
// ----------------------------------------------------------------------------
// Modbus RTU read master control
// Request framing, response parsing with CRC check, word readout sequencing.
// ----------------------------------------------------------------------------
module mrm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mrm_pkg::in_item_t          in_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output mrm_pkg::res_item_t         res_data,
  output logic                       ram_we,
  output logic [mrm_pkg::StoreAw-1:0] ram_waddr,
  output logic [15:0]                ram_wdata,
  output logic                       ram_re,
  output logic [mrm_pkg::StoreAw-1:0] ram_raddr,
  input  logic [15:0]                ram_rdata
);

  localparam int PosW    = mrm_pkg::PosW;
  localparam int PosExtW = mrm_pkg::PosExtW;
  localparam int Aw      = mrm_pkg::StoreAw;

  mrm_pkg::state_t state_r, state_nxt;

  logic [7:0]                  exp_addr_r, exp_addr_nxt;
  logic [7:0]                  exp_func_r, exp_func_nxt;
  logic [4:0]                  exp_cnt_r, exp_cnt_nxt;
  logic [15:0]                 sa_r, sa_nxt;
  logic [mrm_pkg::TxIdxW-1:0]  tx_idx_r, tx_idx_nxt;
  logic [15:0]                 tx_crc_r, tx_crc_nxt;
  logic [PosW-1:0]             pos_r, pos_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [15:0]                 tail_r, tail_nxt;
  logic [7:0]                  bc_r, bc_nxt;
  logic                        ovl_r, ovl_nxt;
  logic                        hdr_r, hdr_nxt;
  logic [Aw-1:0]               wi_r, wi_nxt;

  logic                        in_acc, res_acc;
  logic [7:0]                  rx_b;
  logic                        pos_full;
  logic [PosW-1:0]             pos_e;
  logic [15:0]                 crc_e, tail_e;
  logic [7:0]                  bc_e;
  logic                        ovl_e, hdr_e;
  logic                        frame_ok;
  logic [4:0]                  cnt_clamp;
  logic [PosExtW-1:0]          off_ext;
  logic [PosExtW-2:0]          wi_ext;
  logic [7:0]                  tx_b;
  logic                        word_last;

  assign in_acc  = in_valid && in_ready;
  assign res_acc = res_valid && res_ready;
  assign rx_b    = in_data.rx_byte;

  // response byte update
  always_comb begin
    pos_full = (pos_r >= PosW'(mrm_pkg::MaxFrame));
    pos_e    = pos_r;
    crc_e    = crc_r;
    tail_e   = tail_r;
    bc_e     = bc_r;
    hdr_e    = hdr_r;
    ovl_e    = ovl_r;
    if (pos_full) begin
      ovl_e = 1'b1;
    end else begin
      if (pos_r >= PosW'(2)) begin
        crc_e = mrm_pkg::crc_feed(crc_r, tail_r[15:8]);
      end
      tail_e = {tail_r[7:0], rx_b};
      if ((pos_r == PosW'(0)) && (rx_b != exp_addr_r)) hdr_e = 1'b1;
      if ((pos_r == PosW'(1)) && (rx_b != exp_func_r)) hdr_e = 1'b1;
      if (pos_r == PosW'(2)) bc_e = rx_b;
      pos_e = pos_r + PosW'(1);
    end
    frame_ok = !ovl_e && !hdr_e && (pos_e >= PosW'(5)) &&
               (9'(pos_e) == (9'(bc_e) + 9'd5)) &&
               ({1'b0, bc_e} >= {3'b000, exp_cnt_r, 1'b0}) &&
               (tail_e[15:8] == crc_e[7:0]) && (tail_e[7:0] == crc_e[15:8]);
  end

  // register store write
  always_comb begin
    off_ext   = PosExtW'(pos_r) - PosExtW'(3);
    wi_ext    = off_ext[PosExtW-1:1];
    ram_we    = in_acc && in_data.req_type && !pos_full && (pos_r >= PosW'(3)) &&
                (wi_ext < (PosExtW-1)'(mrm_pkg::StoreDepth));
    ram_waddr = wi_ext[Aw-1:0];
    ram_wdata = off_ext[0] ? {tail_r[7:0], rx_b} : {rx_b, 8'h00};
  end

  always_comb begin
    cnt_clamp = in_data.reg_count;
    if (cnt_clamp == 5'd0) begin
      cnt_clamp = 5'd1;
    end else if (cnt_clamp > 5'(mrm_pkg::CountCap)) begin
      cnt_clamp = 5'(mrm_pkg::CountCap);
    end
  end

  always_comb begin
    unique case (tx_idx_r)
      3'd0:    tx_b = exp_addr_r;
      3'd1:    tx_b = exp_func_r;
      3'd2:    tx_b = sa_r[15:8];
      3'd3:    tx_b = sa_r[7:0];
      3'd4:    tx_b = 8'h00;
      3'd5:    tx_b = {3'b000, exp_cnt_r};
      3'd6:    tx_b = tx_crc_r[7:0];
      default: tx_b = tx_crc_r[15:8];
    endcase
  end

  assign word_last = ((5'(wi_r) + 5'd1) == exp_cnt_r);

  // datapath next values
  always_comb begin
    exp_addr_nxt = exp_addr_r;
    exp_func_nxt = exp_func_r;
    exp_cnt_nxt  = exp_cnt_r;
    sa_nxt       = sa_r;
    tx_idx_nxt   = tx_idx_r;
    tx_crc_nxt   = tx_crc_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    tail_nxt     = tail_r;
    bc_nxt       = bc_r;
    ovl_nxt      = ovl_r;
    hdr_nxt      = hdr_r;
    wi_nxt       = wi_r;
    if (in_acc) begin
      if (!in_data.req_type || in_data.rx_last) begin
        pos_nxt  = '0;
        crc_nxt  = mrm_pkg::CrcInit;
        tail_nxt = '0;
        bc_nxt   = '0;
        ovl_nxt  = 1'b0;
        hdr_nxt  = 1'b0;
        wi_nxt   = '0;
      end else begin
        pos_nxt  = pos_e;
        crc_nxt  = crc_e;
        tail_nxt = tail_e;
        bc_nxt   = bc_e;
        ovl_nxt  = ovl_e;
        hdr_nxt  = hdr_e;
      end
      if (!in_data.req_type) begin
        exp_addr_nxt = in_data.slave_address;
        exp_func_nxt = in_data.function_code;
        exp_cnt_nxt  = cnt_clamp;
        sa_nxt       = in_data.start_address;
        tx_idx_nxt   = '0;
        tx_crc_nxt   = mrm_pkg::CrcInit;
      end
    end
    if (res_acc && (state_r == mrm_pkg::ST_TX)) begin
      tx_idx_nxt = tx_idx_r + 3'd1;
      if (tx_idx_r < mrm_pkg::TxCrcLo) begin
        tx_crc_nxt = mrm_pkg::crc_feed(tx_crc_r, tx_b);
      end
    end
    if (res_acc && (state_r == mrm_pkg::ST_WORD)) begin
      wi_nxt = wi_r + Aw'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrm_pkg::ST_IDLE: begin
        priority if (in_acc && !in_data.req_type) state_nxt = mrm_pkg::ST_TX;
        else if (in_acc && in_data.rx_last) begin
          state_nxt = frame_ok ? mrm_pkg::ST_RD : mrm_pkg::ST_REJ;
        end else begin
          state_nxt = mrm_pkg::ST_IDLE;
        end
      end
      mrm_pkg::ST_TX: begin
        if (res_acc && (tx_idx_r == mrm_pkg::TxLastIdx)) state_nxt = mrm_pkg::ST_IDLE;
      end
      mrm_pkg::ST_RD: state_nxt = mrm_pkg::ST_WORD;
      mrm_pkg::ST_WORD: begin
        if (res_acc) state_nxt = word_last ? mrm_pkg::ST_IDLE : mrm_pkg::ST_RD;
      end
      mrm_pkg::ST_REJ: begin
        if (res_acc) state_nxt = mrm_pkg::ST_IDLE;
      end
      default: state_nxt = mrm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready           = 1'b0;
    res_valid          = 1'b0;
    ram_re             = 1'b0;
    ram_raddr          = wi_r;
    res_data.out_kind  = mrm_pkg::KIND_TX;
    res_data.tx_byte   = 8'h00;
    res_data.reg_value = 16'h0000;
    res_data.reg_index = 4'h0;
    res_data.frame_ok  = 1'b0;
    res_data.last      = 1'b0;
    unique case (state_r)
      mrm_pkg::ST_IDLE: in_ready = 1'b1;
      mrm_pkg::ST_TX: begin
        res_valid        = 1'b1;
        res_data.tx_byte = tx_b;
        res_data.last    = (tx_idx_r == mrm_pkg::TxLastIdx);
      end
      mrm_pkg::ST_RD: ram_re = 1'b1;
      mrm_pkg::ST_WORD: begin
        res_valid          = 1'b1;
        res_data.out_kind  = mrm_pkg::KIND_WORD;
        res_data.reg_value = ram_rdata;
        res_data.reg_index = 4'(wi_r);
        res_data.frame_ok  = 1'b1;
        res_data.last      = word_last;
      end
      mrm_pkg::ST_REJ: begin
        res_valid         = 1'b1;
        res_data.out_kind = mrm_pkg::KIND_REJECT;
        res_data.last     = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mrm_pkg::ST_IDLE;
      exp_addr_r <= '0;
      exp_func_r <= '0;
      exp_cnt_r  <= 5'd1;
      sa_r       <= '0;
      tx_idx_r   <= '0;
      tx_crc_r   <= mrm_pkg::CrcInit;
      pos_r      <= '0;
      crc_r      <= mrm_pkg::CrcInit;
      tail_r     <= '0;
      bc_r       <= '0;
      ovl_r      <= 1'b0;
      hdr_r      <= 1'b0;
      wi_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      exp_addr_r <= exp_addr_nxt;
      exp_func_r <= exp_func_nxt;
      exp_cnt_r  <= exp_cnt_nxt;
      sa_r       <= sa_nxt;
      tx_idx_r   <= tx_idx_nxt;
      tx_crc_r   <= tx_crc_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      tail_r     <= tail_nxt;
      bc_r       <= bc_nxt;
      ovl_r      <= ovl_nxt;
      hdr_r      <= hdr_nxt;
      wi_r       <= wi_nxt;
    end
  end

endmodule

### design/modbus_rtu_read_master.sv
// ----------------------------------------------------------------------------
// Modbus RTU read master
// Builds read requests with CRC-16 and checks responses, unpacking the
// register words of a good frame from the register store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat is a request (req_type 0) or one response byte
//           (req_type 1, rx_last on the frame's final byte).
//   out_* : result beats: 8 transmit bytes per request, then on a response's
//           final byte either one word per register asked for or a single
//           reject beat. last flags the final beat of each burst.
// Sequencing:
//   A response byte that is not final is absorbed without leaving idle. Each
//   word is read from the register store (read state, then word state), and
//   every result beat passes through the output register.
//   Input is not taken while a burst is being produced.
// Reset: synchronous rst_n clears the parser, CRC and expected header; the
//   register store is not cleared and needs no clearing pass.
// Stall: with out_ready low the output register holds its beat and the
//   sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrm_pkg::res_item_t out_data
);

  logic                         res_valid;
  logic                         res_ready;
  mrm_pkg::res_item_t           res_data;
  logic                         ram_we;
  logic [mrm_pkg::StoreAw-1:0]  ram_waddr;
  logic [15:0]                  ram_wdata;
  logic                         ram_re;
  logic [mrm_pkg::StoreAw-1:0]  ram_raddr;
  logic [15:0]                  ram_rdata;

  logic                         out_valid_r;
  mrm_pkg::res_item_t           out_data_r;

  mrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  mrm_ram #(
    .Width (16),
    .Depth (mrm_pkg::StoreDepth)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/mrm_chk.sv
// ----------------------------------------------------------------------------
// Modbus RTU read master port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_read_master_assert.svh"

module mrm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mrm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mrm_pkg::res_item_t out_data
);

  // stalled beat holds
  `MRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a reject closes its burst and is never flagged good
  `MRM_ASSERT_NOW(a_reject_last, out_valid && (out_data.out_kind == mrm_pkg::KIND_REJECT), out_data.last && !out_data.frame_ok)

  // frame_ok marks exactly the register words
  `MRM_ASSERT_NOW(a_ok_word, out_valid, out_data.frame_ok == (out_data.out_kind == mrm_pkg::KIND_WORD))

  // a request beat starts a transmit burst, so input closes
  `MRM_ASSERT_NEXT(a_req_busy, in_valid && in_ready && !in_data.req_type, !in_ready)

endmodule

bind modbus_rtu_read_master mrm_chk u_chk (.*);
